[sv/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, widths and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 31;
  localparam int THR_W  = 16;
  localparam int POS_W  = 32;

  localparam logic [30:0] WB_RESET   = 31'd26870;
  localparam logic [15:0] THR_RESET  = 16'd66;
  localparam logic signed [31:0] HALF_WB_RESET = 32'sd13435;

  // serial unit widths
  localparam int MUL_AW = 44;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 33;
  localparam int SQ_RW  = 31;
  localparam int COR_W  = 34;
  localparam int CS_W   = 19;
  localparam int PX_W   = 43;
  localparam int TX_W   = 44;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [DIV_DW-1:0] Q16_TWO_PI_DIV = 33'd411775;
  localparam logic [63:0] OFFSET_LIMIT = 64'd1099511627776;
  localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-k in Q2.30
  localparam logic [29:0] ATAN_TAB [0:31] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_NORM,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_DIVX,
    ST_DIVY,
    ST_MOVE,
    ST_OFS_MUL,
    ST_OFS_DIV,
    ST_TH_DIV,
    ST_MOD_DIV,
    ST_CORDIC,
    ST_ROT,
    ST_FINISH
  } ddo_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/ddo_mul.sv]
// ----------------------------------------------------------------------------
// ddo_mul
// Serial shift-add multiplier, one multiplier bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::MUL_AW-1:0]  a_i,
  input  logic [ddo_pkg::MUL_BW-1:0]  b_i,
  output logic                        done_o,
  output logic [ddo_pkg::MUL_PW-1:0]  prod_o
);
  import ddo_pkg::*;

  localparam int CntW = $clog2(MUL_BW + 1);

  logic [MUL_AW-1:0] a_q, a_d;
  logic [MUL_PW-1:0] p_q, p_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [MUL_AW:0]   sum;

  always_comb begin
    sum    = {1'b0, p_q[MUL_PW-1:MUL_BW]} + (p_q[0] ? {1'b0, a_q} : '0);
    a_d    = a_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      p_d   = {sum, p_q[MUL_BW-1:1]};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(MUL_BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      a_d    = a_i;
      p_d    = {{MUL_AW{1'b0}}, b_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

[sv/ddo_div.sv]
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::DIV_NW-1:0]  dividend_i,
  input  logic [ddo_pkg::DIV_DW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [ddo_pkg::DIV_NW-1:0]  quot_o,
  output logic [ddo_pkg::DIV_DW-1:0]  rem_o
);
  import ddo_pkg::*;

  localparam int CntW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] n_q, n_d;
  logic [DIV_DW-1:0] rem_q, rem_d, d_q, d_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_DW:0]   sh, diffv;
  logic              qbit;

  always_comb begin
    sh     = {rem_q, n_q[DIV_NW-1]};
    diffv  = sh - {1'b0, d_q};
    qbit   = (sh >= {1'b0, d_q});
    n_d    = n_q;
    rem_d  = rem_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      rem_d = qbit ? diffv[DIV_DW-1:0] : sh[DIV_DW-1:0];
      n_d   = {n_q[DIV_NW-2:0], qbit};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      n_d    = dividend_i;
      d_d    = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    d_q   <= d_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[sv/ddo_sqrt.sv]
// ----------------------------------------------------------------------------
// ddo_sqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [2*ddo_pkg::SQ_RW-1:0]  rad_i,
  output logic                         done_o,
  output logic [ddo_pkg::SQ_RW-1:0]    root_o
);
  import ddo_pkg::*;

  localparam int CntW = $clog2(SQ_RW + 1);
  localparam int RadW = 2 * SQ_RW;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [SQ_RW+1:0] rem_q, rem_d;
  logic [SQ_RW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SQ_RW+3:0] sh, trial, diffv;

  always_comb begin
    sh     = {rem_q, rad_q[RadW-1:RadW-2]};
    trial  = {2'b00, root_q, 2'b01};
    diffv  = sh - trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (sh >= trial) begin
        rem_d  = diffv[SQ_RW+1:0];
        root_d = {root_q[SQ_RW-2:0], 1'b1};
      end else begin
        rem_d  = sh[SQ_RW+1:0];
        root_d = {root_q[SQ_RW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(SQ_RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[sv/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation mode CORDIC, one micro-rotation per cycle, Q3.16 cos and sin out.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ddo_pkg::COR_W-1:0]  z_i,
  input  logic                              flip_i,
  output logic                              done_o,
  output logic signed [ddo_pkg::CS_W-1:0]   cos_o,
  output logic signed [ddo_pkg::CS_W-1:0]   sin_o
);
  import ddo_pkg::*;

  localparam int CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [COR_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [COR_W-1:0] xs, ys, at, xf;
  logic signed [COR_W:0]   xr, yr;
  logic                    flip_q, flip_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [4:0]              k;
  logic                    busy_q, busy_d, done_q, done_d;

  always_comb begin
    k      = 5'(cnt_q);
    xs     = x_q >>> k;
    ys     = y_q >>> k;
    at     = $signed(COR_W'(ATAN_TAB[k]));
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!z_q[COR_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = z_i;
      flip_d = flip_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  // round to Q3.16
  always_comb begin
    xf    = flip_q ? -x_q : x_q;
    xr    = (COR_W + 1)'(xf) + (COR_W + 1)'(8192);
    yr    = (COR_W + 1)'(y_q) + (COR_W + 1)'(8192);
    cos_o = CS_W'(xr >>> 14);
    sin_o = CS_W'(yr >>> 14);
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[sv/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry for a differential drive: tracks both wheel positions.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with the two wheel distances. Output
// channel: out_valid_o / out_stall_i with the four new wheel positions and the
// straight flag, one result per input transfer.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (wheel
// base, straight threshold); unknown indexes are ignored.
// One item is worked on at a time; in_stall_o is high from the transfer until
// the result is loaded into the output register. The work is done by a
// sequencer driving shared bit-serial units: a multiplier, a divider, a
// square root and a CORDIC.
// While the receiver stalls, the finished result stays in the output register
// and the next item can already be taken and worked on; its result waits
// until the register is free.
// Reset puts the wheels at minus and plus half the default wheel base on the
// x axis and restores both registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          left_distance_i,
  input  logic signed [31:0]          right_distance_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          left_pos_x_o,
  output logic signed [31:0]          left_pos_y_o,
  output logic signed [31:0]          right_pos_x_o,
  output logic signed [31:0]          right_pos_y_o,
  output logic                        straight_case_o,
  input  logic                        cfg_we_i,
  input  logic [ddo_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [ddo_pkg::CFG_DW-1:0]  cfg_wdata_i
);
  import ddo_pkg::*;

  localparam logic signed [35:0] PI16   = 36'sd205887;
  localparam logic signed [35:0] TWO16  = 36'sd411775;
  localparam logic signed [35:0] PI30   = 36'sd3373259426;
  localparam logic signed [35:0] HALF30 = 36'sd1686629713;

  ddo_state_e state_q, state_d;

  logic [30:0]        wb_q;
  logic [THR_W-1:0]   thr_q;
  logic signed [31:0] pos_q [4];
  logic signed [31:0] pos_d [4];
  logic signed [31:0] npos_q [4];
  logic signed [31:0] npos_d [4];
  logic signed [31:0] out_pos_q [4];
  logic signed [31:0] out_pos_d [4];
  logic               out_str_q, out_str_d, out_valid_q, out_valid_d;

  logic signed [31:0] l_q, l_d, r_q, r_d;
  logic               straight_q, straight_d;
  logic [29:0]        ax_q, ax_d, ay_q, ay_d;
  logic               fxn_q, fxn_d, fyn_q, fyn_d;
  logic [60:0]        sq_q, sq_d;
  logic [SQ_RW-1:0]   len_q, len_d;
  logic [16:0]        ux_q, ux_d, uy_q, uy_d;
  logic signed [PX_W-1:0] px_q, px_d, py_q, py_d;
  logic signed [CS_W-1:0] cs_q, cs_d, sn_q, sn_d;
  logic signed [63:0] acc_q, acc_d;
  logic [2:0]         term_q, term_d;
  logic               launched_q, launched_d;

  // unit ports
  logic               mul_start, mul_done, div_start, div_done;
  logic               sq_start, sq_done, cor_start, cor_done;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  logic [DIV_NW-1:0]  div_n, div_quot;
  logic [DIV_DW-1:0]  div_dv, div_rem;
  logic [SQ_RW-1:0]   root;
  logic signed [COR_W-1:0] cor_z;
  logic               cor_flip;
  logic signed [CS_W-1:0]  cor_cos, cor_sin;

  // shared combinational values
  logic signed [32:0] diff, fx, fy, dsel;
  logic [32:0]        diff_mag, fx_mag, fy_mag, fxy_or, dsel_mag;
  logic [32:0]        l_mag, r_mag;
  logic               is_straight, out_free, tneg;
  logic signed [TX_W-1:0] tx, ty, ta;
  logic signed [CS_W-1:0] tb;
  logic signed [63:0] mp, term_val, total, rot_res64, mov_res64;
  logic signed [31:0] cur_pos;
  logic [40:0]        qc;
  logic               ofs_neg;
  logic signed [PX_W-1:0] off;
  logic signed [35:0] t0, t1, z0, zf;
  logic [1:0]         mv_idx, rot_idx;

  always_comb begin
    diff     = 33'(r_q) - 33'(l_q);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    l_mag    = l_q[31] ? 33'(-33'(l_q)) : 33'(l_q);
    r_mag    = r_q[31] ? 33'(-33'(r_q)) : 33'(r_q);
    is_straight = (diff_mag < 33'(thr_q)) || (diff_mag == '0);
    fx       = 33'(pos_q[1]) - 33'(pos_q[3]);
    fy       = 33'(pos_q[2]) - 33'(pos_q[0]);
    fx_mag   = fx[32] ? 33'(-fx) : 33'(fx);
    fy_mag   = fy[32] ? 33'(-fy) : 33'(fy);
    fxy_or   = fx_mag | fy_mag;
    dsel     = term_q[0] ? (33'(pos_q[1]) - 33'(pos_q[3]))
                         : (33'(pos_q[0]) - 33'(pos_q[2]));
    dsel_mag = dsel[32] ? 33'(-dsel) : 33'(dsel);
    tx       = term_q[2] ? (TX_W'(pos_q[2]) - TX_W'(px_q))
                         : (TX_W'(pos_q[0]) - TX_W'(px_q));
    ty       = term_q[2] ? (TX_W'(pos_q[3]) - TX_W'(py_q))
                         : (TX_W'(pos_q[1]) - TX_W'(py_q));
    ta       = term_q[0] ? ty : tx;
    tb       = (term_q[1] ^ term_q[0]) ? sn_q : cs_q;
    mv_idx   = term_q[1:0];
    rot_idx  = term_q[2:1];
    cur_pos  = pos_q[mv_idx];
    out_free = !out_valid_q || !out_stall_i;
  end

  // signed product of the current term
  always_comb begin
    if (state_q == ST_ROT) begin
      tneg = ta[TX_W-1] ^ tb[CS_W-1] ^ (!term_q[1] && term_q[0]);
    end else begin
      tneg = (term_q[0] ? fyn_q : fxn_q) ^ (term_q[1] ? r_q[31] : l_q[31]);
    end
    mp        = $signed(mul_p[63:0]);
    term_val  = tneg ? -mp : mp;
    total     = acc_q + term_val;
    rot_res64 = 64'(term_q[1] ? py_q : px_q) + (total >>> 16);
    mov_res64 = 64'(cur_pos) + (term_val >>> 16);
  end

  // centre offset, clamped and signed
  always_comb begin
    qc      = (div_quot > OFFSET_LIMIT) ? OFFSET_LIMIT[40:0] : div_quot[40:0];
    ofs_neg = l_q[31] ^ dsel[32] ^ diff[32];
    off     = ofs_neg ? -$signed(PX_W'(qc)) : $signed(PX_W'(qc));
  end

  // angle reduction and fold into the right half plane
  always_comb begin
    t0 = diff[32] ? -$signed({17'b0, div_rem[18:0]}) : $signed({17'b0, div_rem[18:0]});
    if (t0 > PI16) t1 = t0 - TWO16;
    else if (t0 < -PI16) t1 = t0 + TWO16;
    else t1 = t0;
    z0 = t1 <<< 14;
    if (z0 > HALF30) begin
      zf       = PI30 - z0;
      cor_flip = 1'b1;
    end else if (z0 < -HALF30) begin
      zf       = -PI30 - z0;
      cor_flip = 1'b1;
    end else begin
      zf       = z0;
      cor_flip = 1'b0;
    end
    cor_z = COR_W'(zf);
  end

  // unit operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_dv = '0;
    case (state_q)
      ST_SQX: begin
        mul_a = MUL_AW'(ax_q);
        mul_b = MUL_BW'(ax_q);
      end
      ST_SQY: begin
        mul_a = MUL_AW'(ay_q);
        mul_b = MUL_BW'(ay_q);
      end
      ST_MOVE: begin
        mul_a = MUL_AW'(term_q[1] ? r_mag : l_mag);
        mul_b = MUL_BW'(term_q[0] ? uy_q : ux_q);
      end
      ST_OFS_MUL: begin
        mul_a = MUL_AW'(l_mag);
        mul_b = dsel_mag;
      end
      ST_ROT: begin
        mul_a = ta[TX_W-1] ? MUL_AW'(-ta) : MUL_AW'(ta);
        mul_b = tb[CS_W-1] ? MUL_BW'(-tb) : MUL_BW'(tb);
      end
      ST_DIVX: begin
        div_n  = DIV_NW'({ax_q, 16'h0});
        div_dv = DIV_DW'(len_q);
      end
      ST_DIVY: begin
        div_n  = DIV_NW'({ay_q, 16'h0});
        div_dv = DIV_DW'(len_q);
      end
      ST_OFS_DIV: begin
        div_n  = mul_p[DIV_NW-1:0];
        div_dv = diff_mag;
      end
      ST_TH_DIV: begin
        div_n  = DIV_NW'({diff_mag, 16'h0});
        div_dv = (wb_q == '0) ? DIV_DW'(1) : DIV_DW'(wb_q);
      end
      ST_MOD_DIV: begin
        div_n  = div_quot;
        div_dv = Q16_TWO_PI_DIV;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE:  state_d = is_straight ? ST_NORM : ST_OFS_MUL;
      ST_NORM:    state_d = ST_SQX;
      ST_SQX:     if (mul_done) state_d = ST_SQY;
      ST_SQY:     if (mul_done) state_d = ST_ROOT;
      ST_ROOT:    if (sq_done) state_d = (root == '0) ? ST_FINISH : ST_DIVX;
      ST_DIVX:    if (div_done) state_d = ST_DIVY;
      ST_DIVY:    if (div_done) state_d = ST_MOVE;
      ST_MOVE:    if (mul_done && term_q[1:0] == 2'd3) state_d = ST_FINISH;
      ST_OFS_MUL: if (mul_done) state_d = ST_OFS_DIV;
      ST_OFS_DIV: if (div_done) state_d = term_q[0] ? ST_TH_DIV : ST_OFS_MUL;
      ST_TH_DIV:  if (div_done) state_d = ST_MOD_DIV;
      ST_MOD_DIV: if (div_done) state_d = ST_CORDIC;
      ST_CORDIC:  if (cor_done) state_d = ST_ROT;
      ST_ROT:     if (mul_done && term_q == 3'd7) state_d = ST_FINISH;
      ST_FINISH:  if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    pos_d       = pos_q;
    npos_d      = npos_q;
    out_pos_d   = out_pos_q;
    out_str_d   = out_str_q;
    out_valid_d = out_valid_q && out_stall_i;
    l_d         = l_q;
    r_d         = r_q;
    straight_d  = straight_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    fxn_d       = fxn_q;
    fyn_d       = fyn_q;
    sq_d        = sq_q;
    len_d       = len_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    px_d        = px_q;
    py_d        = py_q;
    cs_d        = cs_q;
    sn_d        = sn_q;
    acc_d       = acc_q;
    term_d      = term_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    sq_start    = 1'b0;
    cor_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          l_d = left_distance_i;
          r_d = right_distance_i;
        end
      end
      ST_DECIDE: begin
        straight_d = is_straight;
        term_d     = '0;
      end
      ST_NORM: begin
        // halve both until they fit in 30 bits
        fxn_d = fx[32];
        fyn_d = fy[32];
        if (fxy_or[32:30] == 3'd0) begin
          ax_d = fx_mag[29:0];
          ay_d = fy_mag[29:0];
        end else if (fxy_or[32:31] == 2'd0) begin
          ax_d = fx_mag[30:1];
          ay_d = fy_mag[30:1];
        end else if (!fxy_or[32]) begin
          ax_d = fx_mag[31:2];
          ay_d = fy_mag[31:2];
        end else begin
          ax_d = {1'b0, fx_mag[32:4]};
          ay_d = {1'b0, fy_mag[32:4]};
        end
        if (fxy_or[32]) begin
          ax_d = fx_mag[32:3];
          ay_d = fy_mag[32:3];
        end
      end
      ST_SQX: begin
        mul_start = !launched_q;
        if (mul_done) sq_d = mul_p[60:0];
      end
      ST_SQY: begin
        mul_start = !launched_q;
        if (mul_done) sq_d = sq_q + mul_p[60:0];
      end
      ST_ROOT: begin
        sq_start = !launched_q;
        if (sq_done) begin
          len_d = root;
          // no axle direction: wheels stay put
          if (root == '0) npos_d = pos_q;
        end
      end
      ST_DIVX: begin
        div_start = !launched_q;
        if (div_done) ux_d = div_quot[16:0];
      end
      ST_DIVY: begin
        div_start = !launched_q;
        if (div_done) uy_d = div_quot[16:0];
      end
      ST_MOVE: begin
        mul_start = !launched_q;
        if (mul_done) begin
          npos_d[mv_idx] = sat32(mov_res64);
          term_d         = term_q + 3'd1;
        end
      end
      ST_OFS_MUL: begin
        mul_start = !launched_q;
      end
      ST_OFS_DIV: begin
        div_start = !launched_q;
        if (div_done) begin
          if (term_q[0]) py_d = PX_W'(pos_q[1]) + off;
          else px_d = PX_W'(pos_q[0]) + off;
          term_d = term_q + 3'd1;
        end
      end
      ST_TH_DIV: begin
        div_start = !launched_q;
      end
      ST_MOD_DIV: begin
        div_start = !launched_q;
      end
      ST_CORDIC: begin
        cor_start = !launched_q;
        if (cor_done) begin
          cs_d   = cor_cos;
          sn_d   = cor_sin;
          term_d = '0;
        end
      end
      ST_ROT: begin
        mul_start = !launched_q;
        if (mul_done) begin
          if (!term_q[0]) acc_d = term_val;
          else npos_d[rot_idx] = sat32(rot_res64);
          term_d = term_q + 3'd1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          pos_d       = npos_q;
          out_pos_d   = npos_q;
          out_str_d   = straight_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    launched_d = launched_q;
    if (mul_start || div_start || sq_start || cor_start) launched_d = 1'b1;
    else if (mul_done || div_done || sq_done || cor_done) launched_d = 1'b0;
  end

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ddo_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ({1'b0, sq_q}),
    .done_o  (sq_done),
    .root_o  (root)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (cor_z),
    .flip_i  (cor_flip),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  always_ff @(posedge clk_i) begin
    npos_q     <= npos_d;
    out_pos_q  <= out_pos_d;
    out_str_q  <= out_str_d;
    l_q        <= l_d;
    r_q        <= r_d;
    straight_q <= straight_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    fxn_q      <= fxn_d;
    fyn_q      <= fyn_d;
    sq_q       <= sq_d;
    len_q      <= len_d;
    ux_q       <= ux_d;
    uy_q       <= uy_d;
    px_q       <= px_d;
    py_q       <= py_d;
    cs_q       <= cs_d;
    sn_q       <= sn_d;
    acc_q      <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= '0;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q[0]    <= -HALF_WB_RESET;
      pos_q[1]    <= '0;
      pos_q[2]    <= HALF_WB_RESET;
      pos_q[3]    <= '0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q  <= WB_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WHEEL_BASE: wb_q  <= cfg_wdata_i;
        REG_THRESHOLD:  thr_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign left_pos_x_o    = out_pos_q[0];
  assign left_pos_y_o    = out_pos_q[1];
  assign right_pos_x_o   = out_pos_q[2];
  assign right_pos_y_o   = out_pos_q[3];
  assign straight_case_o = out_str_q;

endmodule

`default_nettype wire

[verif/differential_drive_odometry_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker
// Watches both channels and the configuration port, predicts the new wheel
// positions of every accepted transfer and compares them with the results.
// ----------------------------------------------------------------------------
module differential_drive_odometry_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic signed [31:0]          left_distance_i,
  input  logic signed [31:0]          right_distance_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [31:0]          left_pos_x_i,
  input  logic signed [31:0]          left_pos_y_i,
  input  logic signed [31:0]          right_pos_x_i,
  input  logic signed [31:0]          right_pos_y_i,
  input  logic                        straight_case_i,
  input  logic                        cfg_we_i,
  input  logic [ddo_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [ddo_pkg::CFG_DW-1:0]  cfg_wdata_i,
  output int                          errors_o,
  output int                          pending_o
);
  import ddo_pkg::*;

  localparam longint PI_Q16     = 205887;
  localparam longint TWO_PI_Q16 = 411775;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HPI_Q30    = 64'sd1686629713;

  typedef struct {
    logic signed [31:0] lx, ly, rx, ry;
    logic               straight;
  } pose_t;

  pose_t  pose_q[$];
  logic [30:0] base_r;
  logic [15:0] thr_r;
  longint lx_s, ly_s, rx_s, ry_s;

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // a*b/c toward zero, clamped; the product fits 64 bits unsigned
  function automatic longint centre_ofs(longint a, longint b, longint c);
    longint unsigned q;
    logic neg;
    q = (longint'(absval(a)) * longint'(absval(b)));
    q = longint'(q / longint'(absval(c)));
    neg = ((a < 0) != (b < 0)) != (c < 0);
    if (q > 64'd1099511627776) q = 64'd1099511627776;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic sin_cos(input longint th, output longint c16, output longint s16);
    longint t, x, y, z, xs, ys;
    logic flip;
    t = th % TWO_PI_Q16;
    if (t > PI_Q16) t -= TWO_PI_Q16;
    if (t < -PI_Q16) t += TWO_PI_Q16;
    z = t * 16384;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (z > HPI_Q30) begin
      z = PI_Q30 - z;
      flip = 1'b1;
    end else if (z < -HPI_Q30) begin
      z = -PI_Q30 - z;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> (i % 32);
      ys = y >>> (i % 32);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i % 32]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i % 32]);
      end
    end
    if (flip) x = -x;
    c16 = shr_floor(x + 8192, 14);
    s16 = shr_floor(y + 8192, 14);
  endtask

  task automatic advance_pose(input longint l, input longint r);
    longint diff, fx, fy, ax, ay, len, ux, uy, wb, px, py, ltx, lty, rtx, rty, c, s;
    pose_t p;
    diff = r - l;
    p.straight = (absval(diff) < longint'(thr_r)) || diff == 0;
    if (p.straight) begin
      fx = -(ry_s - ly_s);
      fy = rx_s - lx_s;
      ax = absval(fx);
      ay = absval(fy);
      while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
        ax >>= 1;
        ay >>= 1;
      end
      len = root_floor(ax * ax + ay * ay);
      if (len != 0) begin
        ux = (ax << 16) / len;
        uy = (ay << 16) / len;
        if (fx < 0) ux = -ux;
        if (fy < 0) uy = -uy;
        lx_s = clip32(lx_s + shr_floor(ux * l, 16));
        ly_s = clip32(ly_s + shr_floor(uy * l, 16));
        rx_s = clip32(rx_s + shr_floor(ux * r, 16));
        ry_s = clip32(ry_s + shr_floor(uy * r, 16));
      end
    end else begin
      wb = base_r != 0 ? longint'(base_r) : 1;
      px = lx_s + centre_ofs(l, lx_s - rx_s, diff);
      py = ly_s + centre_ofs(l, ly_s - ry_s, diff);
      ltx = lx_s - px; lty = ly_s - py;
      rtx = rx_s - px; rty = ry_s - py;
      sin_cos((diff * 65536) / wb, c, s);
      lx_s = clip32(px + shr_floor(ltx * c - lty * s, 16));
      ly_s = clip32(py + shr_floor(ltx * s + lty * c, 16));
      rx_s = clip32(px + shr_floor(rtx * c - rty * s, 16));
      ry_s = clip32(py + shr_floor(rtx * s + rty * c, 16));
    end
    p.lx = lx_s[31:0]; p.ly = ly_s[31:0];
    p.rx = rx_s[31:0]; p.ry = ry_s[31:0];
    pose_q.push_back(p);
  endtask

  task automatic compare(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  assign pending_o = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      base_r <= WB_RESET;
      thr_r  <= THR_RESET;
      lx_s = -longint'(HALF_WB_RESET);
      ly_s = 0;
      rx_s = longint'(HALF_WB_RESET);
      ry_s = 0;
      pose_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WHEEL_BASE) base_r <= cfg_wdata_i;
        else if (cfg_idx_i == REG_THRESHOLD) thr_r <= cfg_wdata_i[15:0];
      end
      if (in_valid_i && !in_stall_i) advance_pose(left_distance_i, right_distance_i);
      if (out_valid_i && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors_o++;
        end else begin
          e = pose_q.pop_front();
          compare("left_pos_x", e.lx, left_pos_x_i);
          compare("left_pos_y", e.ly, left_pos_y_i);
          compare("right_pos_x", e.rx, right_pos_x_i);
          compare("right_pos_y", e.ry, right_pos_y_i);
          compare("straight_case", e.straight, straight_case_i);
        end
      end
    end
  end
endmodule

[verif/differential_drive_odometry_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test
// Drives wheel distance transfers and register writes into the odometry block
// under random idling and one long output hold-off; the checker predicts.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
  import ddo_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] left_distance_i = '0;
  logic signed [31:0] right_distance_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] left_pos_x_o, left_pos_y_o, right_pos_x_o, right_pos_y_o;
  logic straight_case_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  int errors, pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  always #10 clk_i = ~clk_i;

  differential_drive_odometry u_dut (.*);

  differential_drive_odometry_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .left_distance_i, .right_distance_i, .out_valid_i(out_valid_o), .out_stall_i,
    .left_pos_x_i(left_pos_x_o), .left_pos_y_i(left_pos_y_o),
    .right_pos_x_i(right_pos_x_o), .right_pos_y_i(right_pos_y_o),
    .straight_case_i(straight_case_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random stall, or a counted hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen   <= 1'b1;
      hold_cycles <= 2999;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(input logic signed [31:0] l, input logic signed [31:0] r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    left_distance_i <= l;
    right_distance_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_dist();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(65535)) - 32768;
      2: return $signed($urandom_range(16383)) - 8192;
      3: return $signed($urandom_range(1 << 20)) - (1 << 19);
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic random_items(input int n);
    logic signed [31:0] l;
    for (int i = 0; i < n; i++) begin
      l = rand_dist();
      // many near-equal pairs so both updates are exercised
      if ($urandom_range(2) == 0) send(l, l + $signed($urandom_range(200)) - 100);
      else send(l, rand_dist());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, equal pairs, zero, pure turns
    send(32'sh7fffffff, 32'sh7fffffff);
    send(32'sh80000000, 32'sh80000000);
    send(0, 0);
    send(65536, 65536);
    send(-65536, 65536);
    send(32'sh7fffffff, 32'sh80000000);
    send(32'sh80000000, 32'sh7fffffff);
    send(1000, 1065);
    send(1000, 1066);
    send(0, 1);
    send(-1, -1);
    write_reg(REG_THRESHOLD, 31'd0);
    send(500, 500);
    send(500, 501);
    write_reg(REG_WHEEL_BASE, 31'd0);
    send(0, 65536);
    write_reg(REG_WHEEL_BASE, 31'h7fffffff);
    write_reg(REG_THRESHOLD, 31'h0000ffff);
    send(0, 65535);
    send(0, 65536);
    send(32'sh12345678, 32'sh12345678);
    write_reg(REG_WHEEL_BASE, 31'd1);
    send(100, -100);
    write_reg(2'd2, 31'h5555);
    write_reg(REG_WHEEL_BASE, 31'd26870);
    write_reg(REG_THRESHOLD, 31'd66);
    send_idle_pct = 18;
    recv_idle_pct = 51;
    random_items(500);
    write_reg(REG_WHEEL_BASE, 31'($urandom_range(200000, 1)));
    write_reg(REG_THRESHOLD, 31'($urandom_range(65535)));
    send_idle_pct = 51;
    recv_idle_pct = 18;
    random_items(500);
    write_reg(REG_WHEEL_BASE, 31'h7fffffff);
    write_reg(REG_THRESHOLD, 31'($urandom_range(500)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_items(550);
    while (pending != 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end
endmodule
